FILE: hw/rtl/rclr_pkg.sv
// ----------------------------------------------------------------------------
// rclr_pkg
// Shared types, codes and the CRC-8 step for the command link with retry.
// ----------------------------------------------------------------------------
package rclr_pkg;

	localparam int FRAME_BYTES = 20;
	localparam int IDX_W       = $clog2(FRAME_BYTES);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);

	localparam int ELAPSED_W = 17;
	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

	// input commands
	localparam logic [1:0] CMD_NEW  = 2'd0;
	localparam logic [1:0] CMD_TICK = 2'd1;
	localparam logic [1:0] CMD_RX   = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_TX     = 2'd0;
	localparam logic [1:0] KIND_STATUS = 2'd1;
	localparam logic [1:0] KIND_DONE   = 2'd2;

	// reply frame status
	localparam logic [2:0] ST_FINISHED      = 3'd0;
	localparam logic [2:0] ST_RECEIVED      = 3'd1;
	localparam logic [2:0] ST_BAD_CRC       = 3'd2;
	localparam logic [2:0] ST_WRONG_ID      = 3'd3;
	localparam logic [2:0] ST_BAD_HEADER    = 3'd4;
	localparam logic [2:0] ST_MODE_MISMATCH = 3'd5;

	// configuration register indexes
	localparam logic [1:0] REG_PEER_ID       = 2'd0;
	localparam logic [1:0] REG_FORWARD_CODE  = 2'd1;
	localparam logic [1:0] REG_BACKWARD_CODE = 2'd2;
	localparam logic [1:0] REG_RETRY_TICKS   = 2'd3;

	localparam logic [7:0] CRC_POLY    = 8'h07;
	localparam logic [7:0] SYNC_BYTE   = 8'hFF;

	// one frame byte from the transmit sequencer
	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		logic       last;
	} tx_beat_t;

	// crc-8, msb first, no final xor
	function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

FILE: hw/rtl/rclr_frame_tx.sv
// ----------------------------------------------------------------------------
// rclr_frame_tx
// Command frame sequencer: emits one frame byte per cycle while advance is high, CRC last.
// ----------------------------------------------------------------------------
module rclr_frame_tx import rclr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       advance,
	input  logic [7:0] saved_id,
	input  logic [7:0] saved_mode,
	input  logic [7:0] saved_count,
	output logic       active,
	output tx_beat_t   beat
);

	logic             active_q;
	logic [IDX_W-1:0] idx_q;
	logic [7:0]       crc_q;
	logic [7:0]       body;
	logic             at_last;

	assign at_last = (idx_q == LAST_IDX);

	always_comb begin
		case (idx_q)
			IDX_W'(0): body = SYNC_BYTE;
			IDX_W'(2): body = saved_id;
			IDX_W'(3): body = saved_mode;
			IDX_W'(4): body = saved_count;
			default:   body = 8'h00;
		endcase
	end

	assign active     = active_q;
	assign beat.valid = active_q;
	assign beat.data  = at_last ? crc_q : body;
	assign beat.last  = at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= '0;
			crc_q    <= '0;
		end else if (start) begin
			active_q <= 1'b1;
			idx_q    <= '0;
			crc_q    <= '0;
		end else if (active_q && advance) begin
			if (at_last) begin
				active_q <= 1'b0;
			end
			idx_q <= idx_q + 1'b1;
			crc_q <= crc_byte(crc_q, body);
		end
	end

endmodule

FILE: hw/rtl/radio_command_link_retry.sv
// ----------------------------------------------------------------------------
// radio_command_link_retry
// Framed radio command link with CRC-8, reply checking and retransmission.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  in        in_valid / in_ready    command, target_id, move_mode, move_count, rx_byte
//  out       out_valid / out_ready  kind, tx_byte, tx_last, frame_status
//  cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// ticks and received bytes: one item per cycle while the output is free
// and no frame streams; a new command, or a tick that resends, starts a frame
// of FRAME_BYTES bytes: the sequencer owns the output register while it streams
// the input register holds the next item until the sequencer is done
// reset clears all control state and loads register defaults; cfg_ready is
// always high
// ----------------------------------------------------------------------------
module radio_command_link_retry import rclr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [7:0]  target_id,
	input  logic [7:0]  move_mode,
	input  logic [7:0]  move_count,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  tx_byte,
	output logic        tx_last,
	output logic [2:0]  frame_status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	// configuration
	logic [15:0] peer_id_q;
	logic [7:0]  forward_code_q;
	logic [7:0]  backward_code_q;
	logic [15:0] retry_ticks_q;

	// input register
	logic        valid_s1;
	logic [1:0]  command_s1;
	logic [7:0]  target_id_s1;
	logic [7:0]  move_mode_s1;
	logic [7:0]  move_count_s1;
	logic [7:0]  rx_byte_s1;

	// link state
	logic [7:0]           saved_id_q, saved_id_n;
	logic [7:0]           saved_mode_q, saved_mode_n;
	logic [7:0]           saved_count_q, saved_count_n;
	logic                 busy_q, busy_n;
	logic                 sent_q, sent_n;
	logic                 acked_q, acked_n;
	logic [ELAPSED_W-1:0] elapsed_q, elapsed_n, elapsed_inc;
	logic [IDX_W-1:0]     rx_index_q, rx_index_n;
	logic [7:0]           rx_crc_q, rx_crc_n;
	logic [3:0]           rx_flags_q, rx_flags_n;

	// output register
	logic       out_valid_q;
	logic [1:0] kind_q;
	logic [7:0] tx_byte_q;
	logic       tx_last_q;
	logic [2:0] status_q;

	logic       out_free;
	logic       go;
	logic       send;
	logic       res_valid;
	logic [1:0] res_kind;
	logic [2:0] res_status;
	logic       tx_active;
	tx_beat_t   beat;

	assign out_free  = !out_valid_q || out_ready;
	assign go        = valid_s1 && !tx_active && out_free;
	assign in_ready  = !valid_s1 || go;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peer_id_q       <= 16'd1;
			forward_code_q  <= 8'd0;
			backward_code_q <= 8'd1;
			retry_ticks_q   <= 16'd1000;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_PEER_ID:       peer_id_q       <= cfg_data;
				REG_FORWARD_CODE:  forward_code_q  <= cfg_data[7:0];
				REG_BACKWARD_CODE: backward_code_q <= cfg_data[7:0];
				REG_RETRY_TICKS:   retry_ticks_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			command_s1    <= command;
			target_id_s1  <= target_id;
			move_mode_s1  <= move_mode;
			move_count_s1 <= move_count;
			rx_byte_s1    <= rx_byte;
		end
	end

	assign elapsed_inc = (elapsed_q == ELAPSED_MAX) ? elapsed_q : elapsed_q + 1'b1;

	always_comb begin
		saved_id_n    = saved_id_q;
		saved_mode_n  = saved_mode_q;
		saved_count_n = saved_count_q;
		busy_n        = busy_q;
		sent_n        = sent_q;
		acked_n       = acked_q;
		elapsed_n     = elapsed_q;
		rx_index_n    = rx_index_q;
		rx_crc_n      = rx_crc_q;
		rx_flags_n    = rx_flags_q;
		send          = 1'b0;
		res_valid     = 1'b0;
		res_kind      = KIND_TX;
		res_status    = ST_FINISHED;
		if (go) begin
			unique case (command_s1)
				CMD_NEW: begin
					saved_id_n   = target_id_s1;
					saved_mode_n = move_mode_s1;
					if (move_mode_s1 == forward_code_q || move_mode_s1 == backward_code_q) begin
						saved_count_n = move_count_s1;
					end else begin
						saved_count_n = 8'h00;
					end
					busy_n  = 1'b1;
					acked_n = 1'b0;
					send    = 1'b1;
				end
				CMD_TICK: begin
					if (busy_q) begin
						if (!sent_q) begin
							send = 1'b1;
						end else begin
							elapsed_n = elapsed_inc;
							if (elapsed_inc > {1'b0, retry_ticks_q}) begin
								sent_n = 1'b0;
								if (acked_q) begin
									busy_n    = 1'b0;
									elapsed_n = '0;
									res_valid = 1'b1;
									res_kind  = KIND_DONE;
								end
							end
						end
					end
				end
				CMD_RX: begin
					if (rx_index_q >= LAST_IDX) begin
						res_valid = 1'b1;
						res_kind  = KIND_STATUS;
						if (!rx_flags_q[0]) begin
							res_status = ST_BAD_HEADER;
						end else if (!rx_flags_q[1]) begin
							res_status = ST_WRONG_ID;
						end else if (!rx_flags_q[2]) begin
							res_status = ST_MODE_MISMATCH;
						end else begin
							// header, id and mode echoed: counts as acknowledge
							acked_n = 1'b1;
							if (rx_crc_q != rx_byte_s1) begin
								res_status = ST_BAD_CRC;
							end else if (rx_flags_q[3]) begin
								res_status = ST_FINISHED;
							end else begin
								res_status = ST_RECEIVED;
							end
						end
						rx_index_n = '0;
						rx_crc_n   = '0;
						rx_flags_n = '0;
					end else begin
						case (rx_index_q)
							IDX_W'(0): rx_flags_n = {3'b111, rx_byte_s1 == SYNC_BYTE};
							IDX_W'(1): if (rx_byte_s1 != peer_id_q[15:8]) rx_flags_n[1] = 1'b0;
							IDX_W'(2): if (rx_byte_s1 != peer_id_q[7:0]) rx_flags_n[1] = 1'b0;
							IDX_W'(3): if (rx_byte_s1 != saved_mode_q) rx_flags_n[2] = 1'b0;
							IDX_W'(4): if (rx_byte_s1 != saved_count_q) rx_flags_n[3] = 1'b0;
							default: ;
						endcase
						rx_crc_n   = crc_byte(rx_crc_q, rx_byte_s1);
						rx_index_n = rx_index_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
		if (send) begin
			sent_n    = 1'b1;
			elapsed_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			saved_id_q    <= '0;
			saved_mode_q  <= '0;
			saved_count_q <= '0;
			busy_q        <= 1'b0;
			sent_q        <= 1'b0;
			acked_q       <= 1'b0;
			elapsed_q     <= '0;
			rx_index_q    <= '0;
			rx_crc_q      <= '0;
			rx_flags_q    <= '0;
		end else begin
			saved_id_q    <= saved_id_n;
			saved_mode_q  <= saved_mode_n;
			saved_count_q <= saved_count_n;
			busy_q        <= busy_n;
			sent_q        <= sent_n;
			acked_q       <= acked_n;
			elapsed_q     <= elapsed_n;
			rx_index_q    <= rx_index_n;
			rx_crc_q      <= rx_crc_n;
			rx_flags_q    <= rx_flags_n;
		end
	end

	// sequencer reads saved_* after they are registered
	rclr_frame_tx u_frame_tx (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (send),
		.advance     (out_free),
		.saved_id    (saved_id_q),
		.saved_mode  (saved_mode_q),
		.saved_count (saved_count_q),
		.active      (tx_active),
		.beat        (beat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= beat.valid || res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (beat.valid) begin
				kind_q    <= KIND_TX;
				tx_byte_q <= beat.data;
				tx_last_q <= beat.last;
				status_q  <= ST_FINISHED;
			end else begin
				kind_q    <= res_kind;
				tx_byte_q <= 8'h00;
				tx_last_q <= 1'b0;
				status_q  <= res_status;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign tx_byte      = tx_byte_q;
	assign tx_last      = tx_last_q;
	assign frame_status = status_q;

endmodule

FILE: hw/rtl/rclr_checker.sv
// ----------------------------------------------------------------------------
// rclr_checker
// Port-level checks for the command link with retry, bound to the top level.
// ----------------------------------------------------------------------------
module rclr_checker import rclr_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  kind,
	input logic [7:0]  tx_byte,
	input logic        tx_last,
	input logic [2:0]  frame_status
);

	// tx_last only marks transmit bytes
	a_last_is_tx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tx_last |-> kind == KIND_TX)
		else $error("tx_last on a non-transmit result");

	// status field is clean outside status results
	a_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_STATUS |-> frame_status == ST_FINISHED)
		else $error("frame_status set outside a status result");

	// a frame streams without gaps once a byte is taken
	a_frame_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && kind == KIND_TX && !tx_last
		|=> out_valid && kind == KIND_TX)
		else $error("gap or foreign result inside a transmitted frame");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(tx_byte)
		&& $stable(tx_last) && $stable(frame_status))
		else $error("output changed while stalled");

endmodule

bind radio_command_link_retry rclr_checker u_rclr_checker (.*);

FILE: bench/radio_command_link_retry_tb.sv
// ----------------------------------------------------------------------------
// radio_command_link_retry_tb
// Self-checking bench for the framed radio command link with retry.
// Drives new commands, ticks and reply bytes through the input channel and
// keeps its own copy of the link state to work out every transmit byte, reply
// status and command-finished result. Each result is compared field by field
// in arrival order. A few directed sequences come first, then random traffic
// in four idle/stall phases, each under two register settings.
// ----------------------------------------------------------------------------
module radio_command_link_retry_tb;
	import rclr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] CMD_NONE = 2'd3;
	localparam int SETTLE_CYCLES = 2 * FRAME_BYTES;
	localparam int CYCLE_LIMIT = 500_000;
	localparam int ITEMS_PER_SETTING = 28;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic       last;
		logic [2:0] status;
	} link_result_t;

	typedef enum int {
		REPLY_GOOD,
		REPLY_COUNT_OFF,
		REPLY_CRC_OFF,
		REPLY_ID_OFF,
		REPLY_HEADER_OFF,
		REPLY_MODE_OFF
	} reply_flaw_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  command;
	logic [7:0]  target_id;
	logic [7:0]  move_mode;
	logic [7:0]  move_count;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  kind;
	logic [7:0]  tx_byte;
	logic        tx_last;
	logic [2:0]  frame_status;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	radio_command_link_retry dut (.*);

	// register copies
	logic [15:0] reg_peer;
	logic [7:0]  reg_fwd;
	logic [7:0]  reg_bwd;
	logic [15:0] reg_retry;

	// link state copies
	logic [7:0]           cmd_id;
	logic [7:0]           cmd_mode;
	logic [7:0]           cmd_count;
	logic                 cmd_busy;
	logic                 cmd_sent;
	logic                 cmd_acked;
	logic [ELAPSED_W-1:0] wait_count;
	int                   rx_pos;
	logic [7:0]           rx_crc_acc;
	logic [3:0]           rx_ok;

	link_result_t link_results_due[$];

	int send_idle_pct;
	int recv_stall_pct;
	int fail_count;
	int items_accepted;
	int effective_items;
	int results_checked;
	int frames_checked;
	int statuses_checked;
	int finishes_checked;
	int settings_loaded;
	int cycle_count;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] d);
		logic [7:0] r;
		r = acc ^ d;
		repeat (8) r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
		return r;
	endfunction

	// all bytes of one outgoing command frame
	function automatic void queue_command_frame();
		logic [7:0] acc;
		logic [7:0] b;
		acc = 8'h00;
		for (int i = 0; i < FRAME_BYTES - 1; i++) begin
			case (i)
				0: b = SYNC_BYTE;
				2: b = cmd_id;
				3: b = cmd_mode;
				4: b = cmd_count;
				default: b = 8'h00;
			endcase
			acc = crc8_step(acc, b);
			link_results_due.push_back('{KIND_TX, b, 1'b0, 3'd0});
		end
		link_results_due.push_back('{KIND_TX, acc, 1'b1, 3'd0});
		cmd_sent = 1'b1;
		wait_count = '0;
	endfunction

	// returns 0 for items the link ignores
	function automatic bit predict_link_step(input logic [1:0] cmd, input logic [7:0] tid,
			input logic [7:0] mode, input logic [7:0] cnt, input logic [7:0] rxb);
		logic [2:0] st;
		case (cmd)
			CMD_NEW: begin
				cmd_id = tid;
				cmd_mode = mode;
				cmd_count = (mode == reg_fwd || mode == reg_bwd) ? cnt : 8'h00;
				cmd_busy = 1'b1;
				cmd_acked = 1'b0;
				queue_command_frame();
				return 1'b1;
			end
			CMD_TICK: begin
				if (!cmd_busy) return 1'b0;
				if (!cmd_sent) begin
					queue_command_frame();
					return 1'b1;
				end
				if (wait_count != ELAPSED_MAX) wait_count++;
				if (wait_count > {1'b0, reg_retry}) begin
					if (cmd_acked) begin
						cmd_busy = 1'b0;
						cmd_sent = 1'b0;
						wait_count = '0;
						link_results_due.push_back('{KIND_DONE, 8'h00, 1'b0, 3'd0});
					end else begin
						cmd_sent = 1'b0;
					end
				end
				return 1'b1;
			end
			CMD_RX: begin
				if (rx_pos == FRAME_BYTES - 1) begin
					if (!rx_ok[0]) begin
						st = ST_BAD_HEADER;
					end else if (!rx_ok[1]) begin
						st = ST_WRONG_ID;
					end else if (!rx_ok[2]) begin
						st = ST_MODE_MISMATCH;
					end else begin
						cmd_acked = 1'b1;
						if (rx_crc_acc != rxb) st = ST_BAD_CRC;
						else if (rx_ok[3]) st = ST_FINISHED;
						else st = ST_RECEIVED;
					end
					rx_pos = 0;
					rx_crc_acc = 8'h00;
					rx_ok = 4'h0;
					link_results_due.push_back('{KIND_STATUS, 8'h00, 1'b0, st});
				end else begin
					case (rx_pos)
						0: rx_ok = {3'b111, rxb == SYNC_BYTE};
						1: if (rxb != reg_peer[15:8]) rx_ok[1] = 1'b0;
						2: if (rxb != reg_peer[7:0]) rx_ok[1] = 1'b0;
						3: if (rxb != cmd_mode) rx_ok[2] = 1'b0;
						4: if (rxb != cmd_count) rx_ok[3] = 1'b0;
						default: ;
					endcase
					rx_crc_acc = crc8_step(rx_crc_acc, rxb);
					rx_pos++;
				end
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	task automatic push_item(input logic [1:0] cmd, input logic [7:0] tid, input logic [7:0] mode,
			input logic [7:0] cnt, input logic [7:0] rxb);
		int gap;
		if ($urandom_range(0, 99) < send_idle_pct) begin
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 2 * FRAME_BYTES)
				: $urandom_range(1, 3);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		target_id <= tid;
		move_mode <= mode;
		move_count <= cnt;
		rx_byte <= rxb;
		@(posedge clk);
		while (in_ready !== 1'b1) @(posedge clk);
		items_accepted++;
		if (predict_link_step(cmd, tid, mode, cnt, rxb)) effective_items++;
	endtask

	task automatic push_new(input logic [7:0] tid, input logic [7:0] mode, input logic [7:0] cnt);
		push_item(CMD_NEW, tid, mode, cnt, 8'($urandom));
	endtask

	task automatic push_tick();
		push_item(CMD_TICK, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	task automatic push_rx(input logic [7:0] b);
		push_item(CMD_RX, 8'($urandom), 8'($urandom), 8'($urandom), b);
	endtask

	// one reply frame, realigned first if stray bytes are pending
	task automatic send_reply(input reply_flaw_t flaw);
		logic [7:0] frame [FRAME_BYTES];
		logic [7:0] acc;
		while (rx_pos != 0) push_rx(8'($urandom));
		frame[0] = SYNC_BYTE;
		frame[1] = reg_peer[15:8];
		frame[2] = reg_peer[7:0];
		frame[3] = cmd_mode;
		frame[4] = cmd_count;
		for (int i = 5; i < FRAME_BYTES - 1; i++) begin
			frame[i] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00;
		end
		case (flaw)
			REPLY_COUNT_OFF: frame[4] ^= 8'($urandom_range(1, 255));
			REPLY_ID_OFF: begin
				if ($urandom_range(0, 1)) frame[1] ^= 8'($urandom_range(1, 255));
				else frame[2] ^= 8'($urandom_range(1, 255));
			end
			REPLY_HEADER_OFF: frame[0] ^= 8'($urandom_range(1, 255));
			REPLY_MODE_OFF: frame[3] ^= 8'($urandom_range(1, 255));
			default: ;
		endcase
		acc = 8'h00;
		for (int i = 0; i < FRAME_BYTES - 1; i++) acc = crc8_step(acc, frame[i]);
		frame[FRAME_BYTES - 1] = (flaw == REPLY_CRC_OFF) ? acc ^ 8'($urandom_range(1, 255)) : acc;
		for (int i = 0; i < FRAME_BYTES; i++) push_rx(frame[i]);
	endtask

	// drop valid, let every due result drain, then allow the pipeline to settle
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (link_results_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_registers(input logic [15:0] peer, input logic [7:0] fwd,
			input logic [7:0] bwd, input logic [15:0] retry);
		logic [1:0]  order [4];
		logic [15:0] vals [4];
		order = '{REG_PEER_ID, REG_FORWARD_CODE, REG_BACKWARD_CODE, REG_RETRY_TICKS};
		vals = '{peer, {8'h00, fwd}, {8'h00, bwd}, retry};
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= order[i];
			cfg_data <= vals[i];
			@(posedge clk);
			while (cfg_ready !== 1'b1) @(posedge clk);
			case (order[i])
				REG_PEER_ID: reg_peer = vals[i];
				REG_FORWARD_CODE: reg_fwd = vals[i][7:0];
				REG_BACKWARD_CODE: reg_bwd = vals[i][7:0];
				REG_RETRY_TICKS: reg_retry = vals[i];
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
		settings_loaded++;
	endtask

	task automatic test_ignored_items();
		push_tick();
		push_item(CMD_NONE, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		wait_idle();
	endtask

	task automatic test_default_registers();
		push_new(8'hFF, 8'h00, 8'hFF);
		// replaces the running command
		push_new(8'h00, 8'h01, 8'h00);
		// not a move code, count goes out as zero
		push_new(8'h5A, 8'h02, 8'hFF);
		send_reply(REPLY_GOOD);
		wait_idle();
	endtask

	task automatic test_retry_cycle();
		load_registers(16'hA55A, 8'h10, 8'h20, 16'd2);
		push_new(8'h33, 8'h20, 8'h07);
		// third tick runs out with no reply, fourth resends
		repeat (4) push_tick();
		send_reply(REPLY_GOOD);
		repeat (3) push_tick();
		push_tick();
		wait_idle();
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int first_setting);
		int r;
		int n;
		int target;
		logic [7:0] mode;
		logic [7:0] f;
		reply_flaw_t flaw;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int h = 0; h < 2; h++) begin
			wait_idle();
			case (first_setting + h)
				0: load_registers(16'h0000, 8'h00, 8'h00, 16'h0000);
				1: load_registers(16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF);
				2: load_registers(16'hFFFF, 8'h00, 8'hFF, 16'h0000);
				default: begin
					f = 8'($urandom);
					load_registers(16'($urandom), f,
						($urandom_range(0, 3) == 0) ? f : 8'($urandom), 16'($urandom_range(0, 6)));
				end
			endcase
			target = effective_items + ITEMS_PER_SETTING;
			while (effective_items < target) begin
				r = $urandom_range(0, 99);
				if (r < 20) begin
					n = $urandom_range(0, 9);
					mode = (n < 4) ? reg_fwd : (n < 7) ? reg_bwd : 8'($urandom);
					push_new(8'($urandom), mode, 8'($urandom));
				end else if (r < 45) begin
					n = $urandom_range(0, 9);
					flaw = (n < 4) ? REPLY_GOOD : reply_flaw_t'(n - 4);
					send_reply(flaw);
				end else if (r < 80) begin
					n = $urandom_range(1, (reg_retry < 8) ? int'(reg_retry) + 3 : 10);
					repeat (n) push_tick();
				end else if (r < 90) begin
					push_rx(8'($urandom));
				end else begin
					push_item(2'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
				end
			end
		end
	endtask

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// result checker
	always @(posedge clk) begin
		link_result_t due;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
			if (link_results_due.size() == 0) begin
				$error("result with nothing due: kind %0d tx_byte %0h status %0d",
					kind, tx_byte, frame_status);
				fail_count++;
			end else begin
				due = link_results_due.pop_front();
				results_checked++;
				if (due.kind == KIND_TX && due.last) frames_checked++;
				if (due.kind == KIND_STATUS) statuses_checked++;
				if (due.kind == KIND_DONE) finishes_checked++;
				if (kind !== due.kind) begin
					$error("kind: expected %0d, got %0d", due.kind, kind);
					fail_count++;
				end
				if (tx_byte !== due.data) begin
					$error("tx_byte: expected %0h, got %0h", due.data, tx_byte);
					fail_count++;
				end
				if (tx_last !== due.last) begin
					$error("tx_last: expected %0b, got %0b", due.last, tx_last);
					fail_count++;
				end
				if (frame_status !== due.status) begin
					$error("frame_status: expected %0d, got %0d", due.status, frame_status);
					fail_count++;
				end
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d results still due", cycle_count,
			link_results_due.size());
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = CMD_NONE;
		target_id = 8'h00;
		move_mode = 8'h00;
		move_count = 8'h00;
		rx_byte = 8'h00;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_PEER_ID;
		cfg_data = 16'h0000;
		reg_peer = 16'd1;
		reg_fwd = 8'd0;
		reg_bwd = 8'd1;
		reg_retry = 16'd1000;
		cmd_id = 8'h00;
		cmd_mode = 8'h00;
		cmd_count = 8'h00;
		cmd_busy = 1'b0;
		cmd_sent = 1'b0;
		cmd_acked = 1'b0;
		wait_count = '0;
		rx_pos = 0;
		rx_crc_acc = 8'h00;
		rx_ok = 4'h0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		fail_count = 0;
		items_accepted = 0;
		effective_items = 0;
		results_checked = 0;
		frames_checked = 0;
		statuses_checked = 0;
		finishes_checked = 0;
		settings_loaded = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_ignored_items();
		test_default_registers();
		test_retry_cycle();
		test_random_traffic(0, 0, 0);
		test_random_traffic(57, 0, 2);
		test_random_traffic(0, 57, 4);
		test_random_traffic(23, 23, 6);
		wait_idle();

		$display("sent %0d input transactions under %0d register settings in %0d cycles",
			items_accepted, settings_loaded + 1, cycle_count);
		$display("checked %0d results: %0d command frames, %0d reply statuses, %0d finishes",
			results_checked, frames_checked, statuses_checked, finishes_checked);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
